/* rtl/core/monotonic_bezier_interpolate_defines.svh */
// Assertion macros used by the top-level RTL of the interpolator.
`ifndef MONOTONIC_BEZIER_INTERPOLATE_DEFINES_SVH
`define MONOTONIC_BEZIER_INTERPOLATE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MBI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// next-cycle implication
`define MBI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MBI_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define MBI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/mbi_pkg.sv */
package mbi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // input word field order, lowest first
  localparam int FLD_XP   = 0;
  localparam int FLD_XM   = 1;
  localparam int FLD_XN   = 2;
  localparam int FLD_YP   = 3;
  localparam int FLD_YM   = 4;
  localparam int FLD_YN   = 5;
  localparam int FLD_XQ   = 6;
  localparam int N_FIELDS = 7;

  // values carried beside the first divider bank
  localparam int PRE_Y1  = 0;
  localparam int PRE_Y2  = 1;
  localparam int PRE_Y3  = 2;
  localparam int PRE_H1  = 3;
  localparam int PRE_H2  = 4;
  localparam int PRE_DY2 = 5;
  localparam int N_PRE   = 6;

  // values carried beside the slope divider
  localparam int POST_YA   = 0;
  localparam int POST_YB   = 1;
  localparam int POST_Y2   = 2;
  localparam int POST_RLIN = 3;
  localparam int POST_HH   = 4;
  localparam int POST_UU   = 5;
  localparam int POST_VV   = 6;
  localparam int POST_UV   = 7;
  localparam int N_POST    = 8;

  typedef struct packed {
    logic lin;    // x_prev equals x_mid
    logic right;  // right segment (or linear case)
    logic same;   // slopes nonzero and of one sign
    logic fault;  // zero divisor seen so far
  } mbi_flags_t;

  typedef struct packed {
    logic d1;
    logic d2;
    logic s;
    logic u;
  } mbi_zero_t;

  // clamp to a dw-bit signed range
  function automatic logic signed [63:0] q_sat(input logic signed [65:0] v, input int dw);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = (66'sd1 <<< (dw - 1)) - 66'sd1;
    mn = -mx - 66'sd1;
    if (v > mx) return mx[63:0];
    else if (v < mn) return mn[63:0];
    else return v[63:0];
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b, input int dw);
    return q_sat(66'(a) + 66'(b), dw);
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b, input int dw);
    return q_sat(66'(a) - 66'(b), dw);
  endfunction

  // product truncated toward zero to fb fraction bits, then clamped
  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input int dw, input int fb);
    logic signed [127:0] p;
    logic [127:0] mag;
    logic [127:0] m;
    logic [127:0] lim;
    logic [127:0] nv;
    logic neg;
    p   = a * b;
    neg = a[63] ^ b[63];
    mag = p[127] ? 128'(-p) : 128'(p);
    m   = mag >> fb;
    lim = 128'd1 << (dw - 1);
    if (!neg) begin
      nv = lim - 128'd1;
      return (m >= lim) ? nv[63:0] : m[63:0];
    end
    nv = (m >= lim) ? -lim : -m;
    return nv[63:0];
  endfunction

endpackage

/* rtl/core/monotonic_bezier_interpolate.sv */
// Throughput: one word per cycle unless the output stalls; two pipelined restoring
// dividers in series, each DATA_WIDTH+FRAC_BITS stages deep with one quotient bit
// per stage, set the depth. A stall holds the whole pipeline; a two-word output buffer
// keeps input open while one result waits. Reset (rst, synchronous) clears all valid
// bits and the output buffer.
module monotonic_bezier_interpolate import mbi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // x_prev, x_mid, x_next, y_prev, y_mid, y_next, x_query
  input  logic [((N_FIELDS*DATA_WIDTH+7)/8)*8-1:0]  s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // y_interp
  output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_tdata,
  // degenerate
  output logic                                      m_tuser
);

`include "monotonic_bezier_interpolate_defines.svh"

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int OUT_W = ((DW + 7) / 8) * 8;
  localparam int SBU_W = $bits(mbi_flags_t) + N_PRE * DW;
  localparam int SBY_W = $bits(mbi_flags_t) + N_POST * DW;

  function automatic logic signed [DW-1:0] f_add(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_add(64'(a), 64'(b), DW));
  endfunction

  function automatic logic signed [DW-1:0] f_sub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_sub(64'(a), 64'(b), DW));
  endfunction

  logic                        en;
  logic                        a_valid;
  logic [N_FIELDS-1:0][DW-1:0] a_f;
  logic signed [DW-1:0]        xp, xm, xn, yp1, ym, yn, xq;
  logic signed [DW-1:0]        h1_c, h2_c;
  logic                        right_c;

  logic                        b_valid;
  mbi_flags_t                  b_fl;
  logic signed [DW-1:0]        b_dy1, b_hs, b_un, b_ud;
  logic [N_PRE-1:0][DW-1:0]    b_pre;

  logic signed [DW-1:0]        d1, d2, sr, u;
  mbi_zero_t                   zf;
  logic                        u_valid;
  logic [SBU_W-1:0]            u_sb;
  mbi_flags_t                  u_fl;
  logic [N_PRE-1:0][DW-1:0]    u_pre;

  logic                        sl_valid;
  logic signed [DW-1:0]        sl_num, sl_den;
  mbi_flags_t                  sl_fl;
  logic [N_POST-1:0][DW-1:0]   sl_post;

  logic                        y_valid;
  logic signed [DW-1:0]        y_quo;
  logic                        y_zero;
  logic [SBY_W-1:0]            y_sb;
  mbi_flags_t                  y_fl;
  logic [N_POST-1:0][DW-1:0]   y_post;

  logic                        bl_valid;
  logic [DW-1:0]               bl_y;
  logic                        bl_deg;

  logic [1:0]                  cnt;
  logic [1:0]                  cnt_next;
  logic                        push, pop;
  logic [DW-1:0]               h_y, t_y;
  logic                        h_d, t_d;

  // whole pipeline advances unless the output buffer is full and held
  assign en       = (cnt != 2'd2) || m_tready;
  assign s_tready = en;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      a_f <= s_tdata[N_FIELDS*DW-1:0];
    end
  end

  assign xp  = a_f[FLD_XP];
  assign xm  = a_f[FLD_XM];
  assign xn  = a_f[FLD_XN];
  assign yp1 = a_f[FLD_YP];
  assign ym  = a_f[FLD_YM];
  assign yn  = a_f[FLD_YN];
  assign xq  = a_f[FLD_XQ];

  assign h1_c    = f_sub(xm, xp);
  assign h2_c    = f_sub(xn, xm);
  assign right_c = (xp == xm) || (xq > xm);

  // differences and segment choice
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_fl.lin       <= (xp == xm);
      b_fl.right     <= right_c;
      b_fl.same      <= 1'b0;
      b_fl.fault     <= 1'b0;
      b_dy1          <= f_sub(ym, yp1);
      b_hs           <= f_add(h1_c, h2_c);
      b_un           <= right_c ? f_sub(xq, xm) : f_sub(xq, xp);
      b_ud           <= right_c ? h2_c : h1_c;
      b_pre[PRE_Y1]  <= yp1;
      b_pre[PRE_Y2]  <= ym;
      b_pre[PRE_Y3]  <= yn;
      b_pre[PRE_H1]  <= h1_c;
      b_pre[PRE_H2]  <= h2_c;
      b_pre[PRE_DY2] <= f_sub(yn, ym);
    end
  end

  // first divider bank: two secant slopes, weight ratio, segment position
  mbi_div #(.DW(DW), .FB(FB), .SBW(1)) u_div_d1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .num(b_dy1), .den(b_pre[PRE_H1]), .sb_in(1'b0),
    .out_valid(), .quo(d1), .zero(zf.d1), .sb_out()
  );

  mbi_div #(.DW(DW), .FB(FB), .SBW(1)) u_div_d2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .num(b_pre[PRE_DY2]), .den(b_pre[PRE_H2]), .sb_in(1'b0),
    .out_valid(), .quo(d2), .zero(zf.d2), .sb_out()
  );

  mbi_div #(.DW(DW), .FB(FB), .SBW(1)) u_div_s (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .num(b_pre[PRE_H2]), .den(b_hs), .sb_in(1'b0),
    .out_valid(), .quo(sr), .zero(zf.s), .sb_out()
  );

  mbi_div #(.DW(DW), .FB(FB), .SBW(SBU_W)) u_div_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .num(b_un), .den(b_ud), .sb_in({b_fl, b_pre}),
    .out_valid(u_valid), .quo(u), .zero(zf.u), .sb_out(u_sb)
  );

  assign {u_fl, u_pre} = u_sb;

  mbi_slope #(.DW(DW), .FB(FB)) u_slope (
    .clk(clk), .rst(rst), .en(en), .in_valid(u_valid),
    .d1(d1), .d2(d2), .s(sr), .u(u), .zf(zf), .fl_in(u_fl), .pre(u_pre),
    .out_valid(sl_valid), .num(sl_num), .den(sl_den), .fl_out(sl_fl), .post(sl_post)
  );

  // control derivative divider
  mbi_div #(.DW(DW), .FB(FB), .SBW(SBY_W)) u_div_yp (
    .clk(clk), .rst(rst), .en(en), .in_valid(sl_valid),
    .num(sl_num), .den(sl_den), .sb_in({sl_fl, sl_post}),
    .out_valid(y_valid), .quo(y_quo), .zero(y_zero), .sb_out(y_sb)
  );

  assign {y_fl, y_post} = y_sb;

  mbi_blend #(.DW(DW), .FB(FB)) u_blend (
    .clk(clk), .rst(rst), .en(en), .in_valid(y_valid),
    .quo(y_quo), .zero(y_zero), .fl_in(y_fl), .post(y_post),
    .out_valid(bl_valid), .y_interp(bl_y), .degenerate(bl_deg)
  );

  // two-word output buffer
  assign push = bl_valid && en;
  assign pop  = m_tvalid && m_tready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    if (pop) begin
      if (cnt == 2'd2) begin
        h_y <= t_y;
        h_d <= t_d;
      end else if (push) begin
        h_y <= bl_y;
        h_d <= bl_deg;
      end
    end else if (push && cnt == 2'd0) begin
      h_y <= bl_y;
      h_d <= bl_deg;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      t_y <= bl_y;
      t_d <= bl_deg;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = OUT_W'(h_y);
  assign m_tuser  = h_d;

  `MBI_ASSERT_IMPLY(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3)
  `MBI_ASSERT_IMPLY(a_no_overrun, clk, rst, push && cnt == 2'd2, pop)
  `MBI_ASSERT_IMPLY(a_ready_full, clk, rst, !s_tready, cnt == 2'd2 && !m_tready)
  `MBI_ASSERT_NEXT(a_stall_holds, clk, rst, !en, $stable(b_valid) && $stable(b_un))

endmodule

/* rtl/core/mbi_div.sv */
// Pipelined restoring divider: one quotient bit per stage, Q-format result clamped.
module mbi_div import mbi_pkg::*; #(
  parameter int DW  = DATA_WIDTH_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [SBW-1:0]       sb_in,
  output logic                 out_valid,
  output logic signed [DW-1:0] quo,
  output logic                 zero,
  output logic [SBW-1:0]       sb_out
);

  localparam int NB = DW + FB;
  localparam logic [NB-1:0] LIM  = NB'(1) << (DW - 1);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  logic [NB:0]      vld;
  logic [DW-1:0]    nm  [0:NB];
  logic [DW-1:0]    dm  [0:NB];
  logic [DW-1:0]    rem [0:NB];
  logic [NB-1:0]    q   [0:NB];
  logic             neg [0:NB];
  logic             zr  [0:NB];
  logic [SBW-1:0]   sb  [0:NB];

  logic [NB-1:0]    dvd    [0:NB-1];
  logic [DW:0]      trial  [0:NB-1];
  logic             ge     [0:NB-1];
  logic [DW-1:0]    rem_nx [0:NB-1];
  logic [DW-1:0]    num_mag;
  logic [DW-1:0]    den_mag;
  logic [NB-1:0]    qn;
  logic [DW-1:0]    quo_next;

  // operand magnitudes
  assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
  assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

  // one trial subtraction per stage
  always_comb begin
    for (int g = 0; g < NB; g++) begin
      dvd[g]    = {nm[g], {FB{1'b0}}};
      trial[g]  = {rem[g], dvd[g][NB-1-g]};
      ge[g]     = trial[g] >= {1'b0, dm[g]};
      rem_nx[g] = ge[g] ? DW'(trial[g] - {1'b0, dm[g]}) : trial[g][DW-1:0];
    end
  end

  // clamp the quotient magnitude to the signed range
  always_comb begin
    qn = -q[NB];
    if (zr[NB]) begin
      quo_next = '0;
    end else if (neg[NB]) begin
      quo_next = (q[NB] >= LIM) ? MINV : qn[DW-1:0];
    end else begin
      quo_next = (q[NB] >= LIM) ? MAXV : q[NB][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NB-1:0], in_valid};
      out_valid <= vld[NB];
    end
    if (en) begin
      nm[0]  <= num_mag;
      dm[0]  <= den_mag;
      rem[0] <= '0;
      q[0]   <= '0;
      neg[0] <= num[DW-1] ^ den[DW-1];
      zr[0]  <= (den == '0);
      sb[0]  <= sb_in;
      for (int g = 0; g < NB; g++) begin
        nm[g+1]  <= nm[g];
        dm[g+1]  <= dm[g];
        rem[g+1] <= rem_nx[g];
        q[g+1]   <= {q[g][NB-2:0], ge[g]};
        neg[g+1] <= neg[g];
        zr[g+1]  <= zr[g];
        sb[g+1]  <= sb[g];
      end
      quo    <= quo_next;
      zero   <= zr[NB];
      sb_out <= sb[NB];
    end
  end

endmodule

/* rtl/core/mbi_slope.sv */
// Weighted harmonic-mean slope: numerator and denominator of the control derivative,
// plus the basis products of the Bezier blend, over five stages.
module mbi_slope import mbi_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [DW-1:0]          d1,
  input  logic signed [DW-1:0]          d2,
  input  logic signed [DW-1:0]          s,
  input  logic signed [DW-1:0]          u,
  input  mbi_zero_t                     zf,
  input  mbi_flags_t                    fl_in,
  input  logic [N_PRE-1:0][DW-1:0]      pre,
  output logic                          out_valid,
  output logic signed [DW-1:0]          num,
  output logic signed [DW-1:0]          den,
  output mbi_flags_t                    fl_out,
  output logic [N_POST-1:0][DW-1:0]     post
);

  localparam logic [DW-1:0] ONE   = DW'(1) << FB;
  localparam logic [DW-1:0] HALF  = DW'(1) << (FB - 1);
  localparam logic [DW-1:0] THIRD = DW'(((64'd3333 << FB) + 64'd5000) / 64'd10000);

  function automatic logic signed [DW-1:0] f_add(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_add(64'(a), 64'(b), DW));
  endfunction

  function automatic logic signed [DW-1:0] f_sub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_sub(64'(a), 64'(b), DW));
  endfunction

  function automatic logic signed [DW-1:0] f_mul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_mul(64'(a), 64'(b), DW, FB));
  endfunction

  logic                      p1_valid, p2_valid, p3_valid, p4_valid;
  mbi_flags_t                p1_fl, p2_fl, p3_fl, p4_fl;
  mbi_flags_t                p1_fl_next;
  logic signed [DW-1:0]      p1_t, p1_num, p1_lp, p1_hh, p1_v, p1_u, p1_d1, p1_d2;
  logic signed [DW-1:0]      p1_y1, p1_y2, p1_y3;
  logic signed [DW-1:0]      p2_a, p2_num, p2_d1, p2_d2;
  logic signed [DW-1:0]      p3_oma, p3_m1, p3_num, p3_d1;
  logic signed [DW-1:0]      p4_m1, p4_m2, p4_num;
  logic [N_POST-1:0][DW-1:0] p2_post, p3_post, p4_post;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p1_valid  <= in_valid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      p4_valid  <= p3_valid;
      out_valid <= p4_valid;
    end
  end

  // sign test and fault merge
  always_comb begin
    p1_fl_next       = fl_in;
    p1_fl_next.same  = (d1 != '0) && (d2 != '0) && (d1[DW-1] == d2[DW-1]);
    p1_fl_next.fault = fl_in.lin ? zf.u : (zf.d1 | zf.d2 | zf.s | zf.u);
  end

  // P1: weight sum, slope product, flags, first products
  always_ff @(posedge clk) begin
    if (en) begin
      p1_t        <= f_add(ONE, s);
      p1_num      <= f_mul(d1, d2);
      p1_fl       <= p1_fl_next;
      p1_lp       <= f_mul(u, pre[PRE_DY2]);
      p1_hh       <= f_mul(fl_in.right ? pre[PRE_H2] : pre[PRE_H1], HALF);
      p1_v        <= f_sub(ONE, u);
      p1_u        <= u;
      p1_d1       <= d1;
      p1_d2       <= d2;
      p1_y1       <= pre[PRE_Y1];
      p1_y2       <= pre[PRE_Y2];
      p1_y3       <= pre[PRE_Y3];
    end
  end

  // P2: weight, linear result, basis squares and cross product
  always_ff @(posedge clk) begin
    if (en) begin
      p2_a               <= f_mul(THIRD, p1_t);
      p2_num             <= p1_num;
      p2_d1              <= p1_d1;
      p2_d2              <= p1_d2;
      p2_fl              <= p1_fl;
      p2_post[POST_YA]   <= p1_fl.right ? p1_y2 : p1_y1;
      p2_post[POST_YB]   <= p1_fl.right ? p1_y3 : p1_y2;
      p2_post[POST_Y2]   <= p1_y2;
      p2_post[POST_RLIN] <= f_add(p1_y2, p1_lp);
      p2_post[POST_HH]   <= p1_hh;
      p2_post[POST_UU]   <= f_mul(p1_u, p1_u);
      p2_post[POST_VV]   <= f_mul(p1_v, p1_v);
      p2_post[POST_UV]   <= f_mul(p1_u, p1_v);
    end
  end

  // P3: complement weight and first denominator term
  always_ff @(posedge clk) begin
    if (en) begin
      p3_oma  <= f_sub(ONE, p2_a);
      p3_m1   <= f_mul(p2_a, p2_d2);
      p3_num  <= p2_num;
      p3_d1   <= p2_d1;
      p3_fl   <= p2_fl;
      p3_post <= p2_post;
    end
  end

  // P4: second denominator term
  always_ff @(posedge clk) begin
    if (en) begin
      p4_m1   <= p3_m1;
      p4_m2   <= f_mul(p3_oma, p3_d1);
      p4_num  <= p3_num;
      p4_fl   <= p3_fl;
      p4_post <= p3_post;
    end
  end

  // P5: denominator
  always_ff @(posedge clk) begin
    if (en) begin
      den    <= f_add(p4_m1, p4_m2);
      num    <= p4_num;
      fl_out <= p4_fl;
      post   <= p4_post;
    end
  end

endmodule

/* rtl/core/mbi_blend.sv */
// Bezier blend: control point, weighted sum, case select over four stages.
module mbi_blend import mbi_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [DW-1:0]      quo,
  input  logic                      zero,
  input  mbi_flags_t                fl_in,
  input  logic [N_POST-1:0][DW-1:0] post,
  output logic                      out_valid,
  output logic [DW-1:0]             y_interp,
  output logic                      degenerate
);

  function automatic logic signed [DW-1:0] f_add(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_add(64'(a), 64'(b), DW));
  endfunction

  function automatic logic signed [DW-1:0] f_sub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_sub(64'(a), 64'(b), DW));
  endfunction

  function automatic logic signed [DW-1:0] f_mul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return DW'(q_mul(64'(a), 64'(b), DW, FB));
  endfunction

  logic                 q1_valid, q2_valid, q3_valid;
  mbi_flags_t           q1_fl, q2_fl, q3_fl;
  mbi_flags_t           q1_fl_next;
  logic signed [DW-1:0] q1_w, q1_t0, q1_t1, q1_uv, q1_y2, q1_rlin;
  logic signed [DW-1:0] q2_c, q2_t0, q2_t1, q2_uv, q2_y2, q2_rlin;
  logic signed [DW-1:0] q3_t2, q3_s01, q3_y2, q3_rlin;
  logic signed [DW-1:0] yp;
  logic signed [DW-1:0] r_bez;

  // derivative is zero at an extremum or where a secant is flat
  assign yp = fl_in.same ? quo : '0;

  // slope divider fault counts only when its quotient is used
  always_comb begin
    q1_fl_next       = fl_in;
    q1_fl_next.fault = fl_in.fault | (fl_in.same & zero);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid  <= 1'b0;
      q2_valid  <= 1'b0;
      q3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      q1_valid  <= in_valid;
      q2_valid  <= q1_valid;
      q3_valid  <= q2_valid;
      out_valid <= q3_valid;
    end
  end

  // Q1: control offset and end-point terms
  always_ff @(posedge clk) begin
    if (en) begin
      q1_fl       <= q1_fl_next;
      q1_w        <= f_mul(post[POST_HH], yp);
      q1_t0       <= f_mul(post[POST_VV], post[POST_YA]);
      q1_t1       <= f_mul(post[POST_UU], post[POST_YB]);
      q1_uv       <= post[POST_UV];
      q1_y2       <= post[POST_Y2];
      q1_rlin     <= post[POST_RLIN];
    end
  end

  // Q2: control point
  always_ff @(posedge clk) begin
    if (en) begin
      q2_c    <= q1_fl.right ? f_add(q1_y2, q1_w) : f_sub(q1_y2, q1_w);
      q2_t0   <= q1_t0;
      q2_t1   <= q1_t1;
      q2_uv   <= q1_uv;
      q2_y2   <= q1_y2;
      q2_rlin <= q1_rlin;
      q2_fl   <= q1_fl;
    end
  end

  // Q3: middle term and end-point sum
  always_ff @(posedge clk) begin
    if (en) begin
      q3_t2   <= f_mul(q2_uv, q2_c);
      q3_s01  <= f_add(q2_t0, q2_t1);
      q3_y2   <= q2_y2;
      q3_rlin <= q2_rlin;
      q3_fl   <= q2_fl;
    end
  end

  assign r_bez = f_add(q3_s01, f_add(q3_t2, q3_t2));

  // Q4: final select
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (q3_fl.fault) begin
        y_interp <= q3_y2;
      end else if (q3_fl.lin) begin
        y_interp <= q3_rlin;
      end else begin
        y_interp <= r_bez;
      end
      degenerate <= q3_fl.fault;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mbi_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IN_BITS = ((N_FIELDS * DW + 7) / 8) * 8;
  localparam int OUT_BITS = ((DW + 7) / 8) * 8;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint Q_ONE = 64'sd65536;
  localparam longint Q_HALF = 64'sd32768;
  localparam longint Q_THIRD = 64'sd21843;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic signed [31:0] xp, xm, xn, yp, ym, yn, xq;
  } point_set_t;

  typedef struct {
    logic [31:0] y;
    logic        degen;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;
  logic m_tuser;

  interp_t interp_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit zero_div;

  monotonic_bezier_interpolate dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Q16.16 helpers, all results clamped to 32 bits signed
  function automatic longint clamp_q(input logic signed [127:0] v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return longint'(v);
  endfunction

  function automatic longint signed_mag(input bit neg, input logic [127:0] m);
    if (!neg) return (m > 128'(Q_MAX)) ? Q_MAX : longint'(m);
    if (m >= 128'd2147483648) return Q_MIN;
    return -longint'(m);
  endfunction

  function automatic longint add_q(input longint a, input longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_q(wa + wb);
  endfunction

  function automatic longint sub_q(input longint a, input longint b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_q(wa - wb);
  endfunction

  function automatic longint mul_q(input longint a, input longint b);
    logic signed [127:0] wa, wb, p;
    logic [127:0] m;
    wa = a;
    wb = b;
    p = wa * wb;
    m = (p < 0) ? 128'(-p) : 128'(p);
    return signed_mag((a < 0) != (b < 0), m >> FB);
  endfunction

  // divide sets zero_div on a zero divisor
  function automatic longint div_q(input longint a, input longint b);
    logic [127:0] ma, mb;
    if (b == 0) begin
      zero_div = 1'b1;
      return 0;
    end
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    return signed_mag((a < 0) != (b < 0), (ma << FB) / mb);
  endfunction

  function automatic interp_t bezier_interp(input point_set_t p);
    longint x1, x2, x3, y1, y2, y3, x, r;
    longint h1, h2, d1, d2, a, yp, u, c, ya, yb, v, t0, t1, t2, den;
    interp_t o;
    x1 = p.xp; x2 = p.xm; x3 = p.xn;
    y1 = p.yp; y2 = p.ym; y3 = p.yn; x = p.xq;
    zero_div = 1'b0;
    if (x1 == x2) begin
      u = div_q(sub_q(x, x2), sub_q(x3, x2));
      r = add_q(y2, mul_q(u, sub_q(y3, y2)));
    end else begin
      h1 = sub_q(x2, x1);
      h2 = sub_q(x3, x2);
      d1 = div_q(sub_q(y2, y1), h1);
      d2 = div_q(sub_q(y3, y2), h2);
      a = mul_q(Q_THIRD, add_q(Q_ONE, div_q(h2, add_q(h1, h2))));
      yp = 0;
      // harmonic-mean slope only when both secants agree in sign
      if (d1 != 0 && d2 != 0 && ((d1 < 0) == (d2 < 0))) begin
        den = add_q(mul_q(a, d2), mul_q(sub_q(Q_ONE, a), d1));
        yp = div_q(mul_q(d1, d2), den);
      end
      if (x > x2) begin
        u = div_q(sub_q(x, x2), h2);
        c = add_q(y2, mul_q(mul_q(h2, Q_HALF), yp));
        ya = y2;
        yb = y3;
      end else begin
        u = div_q(sub_q(x, x1), h1);
        c = sub_q(y2, mul_q(mul_q(h1, Q_HALF), yp));
        ya = y1;
        yb = y2;
      end
      v = sub_q(Q_ONE, u);
      t0 = mul_q(mul_q(v, v), ya);
      t1 = mul_q(mul_q(u, u), yb);
      t2 = mul_q(mul_q(u, v), c);
      r = add_q(add_q(t0, t1), add_q(t2, t2));
    end
    if (zero_div) r = y2;
    o.y = r[31:0];
    o.degen = zero_div;
    return o;
  endfunction

  function automatic point_set_t unpack_points(input logic [IN_BITS-1:0] d);
    point_set_t p;
    p.xp = d[FLD_XP*DW +: DW];
    p.xm = d[FLD_XM*DW +: DW];
    p.xn = d[FLD_XN*DW +: DW];
    p.yp = d[FLD_YP*DW +: DW];
    p.ym = d[FLD_YM*DW +: DW];
    p.yn = d[FLD_YN*DW +: DW];
    p.xq = d[FLD_XQ*DW +: DW];
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // drive one word, with an optional idle burst first
  task automatic send_points(input point_set_t p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.xq, p.yn, p.ym, p.yp, p.xn, p.xm, p.xp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic go_idle_and_drain();
    s_tvalid <= 1'b0;
    while (interp_q.size() != 0) @(posedge clk);
  endtask

  function automatic point_set_t pts(input logic [31:0] xp, xm, xn, yp, ym, yn, xq);
    point_set_t p;
    p.xp = xp; p.xm = xm; p.xn = xn; p.yp = yp; p.ym = ym; p.yn = yn; p.xq = xq;
    return p;
  endfunction

  function automatic point_set_t random_points(input bit well_formed);
    point_set_t p;
    int step1, step2;
    if (!well_formed) begin
      p = pts($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return p;
    end
    // sorted abscissae in a modest range, query near the span
    step1 = $urandom_range(1, 8 << 16);
    step2 = $urandom_range(1, 8 << 16);
    p.xp = $signed($urandom_range(0, 64 << 16)) - (32 << 16);
    p.xm = ($urandom_range(0, 9) == 0) ? p.xp : p.xp + step1;
    p.xn = p.xm + step2;
    p.yp = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    p.ym = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    p.yn = ($urandom_range(0, 7) == 0) ? p.ym :
           $signed($urandom_range(0, 200 << 16)) - (100 << 16);
    p.xq = p.xp + $signed($urandom_range(0, step1 + step2 + (4 << 16))) - (2 << 16);
    return p;
  endfunction

  // scoreboard: check results, then record accepted words
  always @(posedge clk) begin
    interp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (interp_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
      end else begin
        want = interp_q.pop_front();
        if (m_tdata[31:0] !== want.y) report_mismatch("y_interp", m_tdata[31:0], want.y);
        if (m_tuser !== want.degen) begin
          report_mismatch("degenerate", 32'(m_tuser), 32'(want.degen));
        end
      end
    end
    if (!rst && s_tvalid && s_tready) interp_q.push_back(bezier_interp(unpack_points(s_tdata)));
  end

  // receiver backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_points(pts(mx, mx, mx, mx, mx, mx, mx));
    send_points(pts(mn, mn, mn, mn, mn, mn, mn));
    send_points(pts(mn, mx, mn, mx, mn, mx, mn));
    send_points(pts(0, 0, 1 << 16, 0, 1 << 16, 3 << 16, 1 << 15));      // linear
    send_points(pts(0, 0, 0, 0, 5 << 16, 3 << 16, 1 << 16));            // linear, zero span
    send_points(pts(0, 1 << 16, 0, 0, 1 << 16, 2 << 16, 1 << 15));      // h1 + h2 zero
    send_points(pts(0, 1 << 16, 2 << 16, 0, 1 << 16, 3 << 16, 3 << 15)); // right, monotone
    send_points(pts(0, 1 << 16, 2 << 16, 0, 1 << 16, 3 << 16, 1 << 15)); // left, monotone
    send_points(pts(0, 1 << 16, 2 << 16, 0, 2 << 16, 0, 3 << 15));      // extremum
    send_points(pts(0, 1 << 16, 2 << 16, 1 << 16, 1 << 16, 4 << 16, 3 << 15)); // flat left
    send_points(pts(0, 1 << 16, 2 << 16, 0, 1 << 16, 3 << 16, 1 << 16)); // query at mid
    send_points(pts(0, 1 << 16, 2 << 16, 0, 1 << 16, 3 << 16, 40 << 16)); // extrapolate
    send_points(pts(0, 1 << 16, 2 << 16, 0, 1 << 16, 3 << 16, mn));      // far left
    send_points(pts(mn, 0, mx, mn, 0, mx, 0));
    send_points(pts(0, 1, 2, mn, 0, mx, 5));                            // tiny spans
    send_points(pts(3 << 16, 1 << 16, 0, 2 << 16, 1 << 16, 0, 2 << 16)); // reversed
    send_points(pts(0, 1 << 16, 3 << 16, 3 << 16, 0, 3 << 16, 2 << 16)); // valley
    send_points(pts(0, 1 << 16, 2 << 16, 0, 100 << 16, 101 << 16, 3 << 15)); // slopes of very unequal size
    go_idle_and_drain();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_points(random_points($urandom_range(0, 9) != 0));
  endtask

  // block the output so the pipeline fills and input stalls
  task automatic test_long_hold();
    hold_req = 1'b1;
    repeat (300) send_points(random_points(1'b1));
    go_idle_and_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    go_idle_and_drain();
    test_long_hold();
    test_random(400);
    idle_on = 1'b0;
    test_random(200);
    go_idle_and_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mbi_pkg.sv
rtl/core/mbi_div.sv
rtl/core/mbi_slope.sv
rtl/core/mbi_blend.sv
rtl/core/monotonic_bezier_interpolate.sv
dv/testbench.sv
